>>> rtl/xxcb_pkg.sv
// Shared constants, codes and handshake types of the XON/XOFF console buffer.
package xxcb_pkg;

   localparam int RX_DEPTH_DEF = 64;
   localparam int TX_DEPTH_DEF = 32;
   localparam int CHUNK_DEF    = 16;

   localparam int FUNC_W     = 3;
   localparam int DATA_W     = 8;
   localparam int KIND_W     = 3;
   localparam int RX_COUNT_W = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DATA_W-1:0] NEWLINE = 8'h0A;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH  = 3'd0,
      FUNC_READ  = 3'd1,
      FUNC_PEEK  = 3'd2,
      FUNC_WRITE = 3'd3,
      FUNC_FLUSH = 3'd4,
      FUNC_QUERY = 3'd5
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STATUS = 3'd0,
      KIND_BYTE   = 3'd1,
      KIND_XON    = 3'd2,
      KIND_XOFF   = 3'd3,
      KIND_TX     = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EXTRA,
      ST_TX_LOAD,
      ST_TX_SEND
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic extra;
      logic tx_load;
      logic tx_send;
   } ctrl_cmd_type;

   typedef struct packed {
      logic tx_go;
      logic extra_go;
      logic tx_last;
   } dp_sts_type;

endpackage

>>> rtl/xxcb_ctrl.sv
// Controller state machine that sequences one transaction through the datapath.
module xxcb_ctrl
   import xxcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  dp_sts_type   sts,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.tx_go) begin
               state_in = ST_TX_LOAD;
            end else if (sts.extra_go) begin
               state_in = ST_EXTRA;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EXTRA: begin
            cmd.extra = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_TX_LOAD: begin
            cmd.tx_load = 1'b1;
            state_in    = ST_TX_SEND;
         end
         ST_TX_SEND: begin
            cmd.tx_send = 1'b1;
            if (sts.tx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/xxcb_datapath.sv
// Datapath: receive FIFO, transmit line buffer, flow-control flag, CSR and result registers.
module xxcb_datapath
   import xxcb_pkg::*;
#(
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int CHUNK    = CHUNK_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_sts_type            sts,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [DATA_W-1:0]     req_data,
   input  logic                  req_push_last,
   input  logic                  req_send_ok,
   input  logic                  cfg_wr,
   input  logic                  cfg_sel,
   input  logic [CSR_DATA_W-1:0] cfg_wdata,
   output logic [CSR_DATA_W-1:0] cfg_rdata,
   output logic                  rsp_valid,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [DATA_W-1:0]     rsp_byte_out,
   output logic                  rsp_byte_valid,
   output logic                  rsp_accepted,
   output logic [RX_COUNT_W-1:0] rsp_rx_count,
   output logic                  rsp_frame_end,
   output logic                  rsp_last
);

   localparam int RX_IDX_W  = $clog2(RX_DEPTH);
   localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
   localparam int RX_SUM_W  = RX_FILL_W + 1;
   localparam int RX_HI     = (RX_DEPTH * 3) / 4;
   localparam int RX_LO     = RX_DEPTH / 4;
   localparam int TX_IDX_W  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);
   localparam int CHK_W     = (CHUNK > 1) ? $clog2(CHUNK) : 1;

   // memories
   logic [DATA_W-1:0] rx_mem [RX_DEPTH];
   logic [DATA_W-1:0] tx_mem [TX_DEPTH];
   logic [DATA_W-1:0] rx_rd_ff;
   logic [DATA_W-1:0] tx_rd_ff;

   // captured transaction
   func_type          func_ff;
   logic [DATA_W-1:0] data_ff;
   logic              plast_ff;
   logic              ok_ff;

   // state
   logic [RX_IDX_W-1:0]  rx_head_ff, rx_head_in;
   logic [RX_FILL_W-1:0] rx_fill_ff, rx_fill_in;
   logic                 xoff_ff, xoff_in;
   logic [TX_FILL_W-1:0] tx_fill_ff, tx_fill_in;
   logic                 enabled_ff, enabled_in;
   logic [TX_FILL_W-1:0] send_cnt_ff, send_cnt_in;
   logic [TX_FILL_W-1:0] idx_ff, idx_in;
   logic [CHK_W-1:0]     chk_ff, chk_in;
   logic                 acc_ff, acc_in;
   kind_type             xkind_ff, xkind_in;

   // result registers
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [DATA_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                  rsp_bvalid_ff, rsp_bvalid_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic [RX_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_fend_ff, rsp_fend_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                 rx_wr_en;
   logic [RX_IDX_W-1:0]  rx_wr_addr;
   logic [RX_SUM_W-1:0]  rx_sum;
   logic                 tx_wr_en;
   logic [TX_IDX_W-1:0]  tx_rd_addr;
   logic [TX_FILL_W-1:0] tx_new;
   logic                 tx_flush;
   logic                 tx_last;

   // tail position of the receive FIFO, wrapped with one compare and subtract
   always_comb begin
      rx_sum = RX_SUM_W'(rx_head_ff) + RX_SUM_W'(rx_fill_ff);
      if (rx_sum >= RX_SUM_W'(RX_DEPTH)) begin
         rx_sum = rx_sum - RX_SUM_W'(RX_DEPTH);
      end
      rx_wr_addr = rx_sum[RX_IDX_W-1:0];
   end

   assign tx_new  = tx_fill_ff + TX_FILL_W'(1);
   assign tx_last = ((idx_ff + TX_FILL_W'(1)) == send_cnt_ff);

   always_comb begin
      rx_head_in    = rx_head_ff;
      rx_fill_in    = rx_fill_ff;
      xoff_in       = xoff_ff;
      tx_fill_in    = tx_fill_ff;
      enabled_in    = enabled_ff;
      send_cnt_in   = send_cnt_ff;
      idx_in        = idx_ff;
      chk_in        = chk_ff;
      acc_in        = acc_ff;
      xkind_in      = xkind_ff;
      rx_wr_en      = 1'b0;
      tx_wr_en      = 1'b0;
      tx_flush      = 1'b0;
      sts           = '0;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_STATUS;
      rsp_byte_in   = '0;
      rsp_bvalid_in = 1'b0;
      rsp_acc_in    = 1'b0;
      rsp_count_in  = RX_COUNT_W'(rx_fill_ff);
      rsp_fend_in   = 1'b0;
      rsp_last_in   = 1'b1;

      if (cmd.exec) begin
         unique case (func_ff)
            FUNC_PUSH: begin
               if (rx_fill_ff != RX_FILL_W'(RX_DEPTH)) begin
                  rx_wr_en   = 1'b1;
                  rx_fill_in = rx_fill_ff + RX_FILL_W'(1);
               end
               if (plast_ff && !xoff_ff && ok_ff && (rx_fill_in > RX_FILL_W'(RX_HI))) begin
                  xoff_in      = 1'b1;
                  xkind_in     = KIND_XOFF;
                  sts.extra_go = 1'b1;
               end
            end
            FUNC_READ, FUNC_PEEK: begin
               if (rx_fill_ff != '0) begin
                  rsp_kind_in   = KIND_BYTE;
                  rsp_byte_in   = rx_rd_ff;
                  rsp_bvalid_in = 1'b1;
                  if (func_ff == FUNC_READ) begin
                     rx_head_in = (rx_head_ff == RX_IDX_W'(RX_DEPTH - 1)) ? '0 :
                                  rx_head_ff + RX_IDX_W'(1);
                     rx_fill_in = rx_fill_ff - RX_FILL_W'(1);
                     if (xoff_ff && ok_ff && (rx_fill_in < RX_FILL_W'(RX_LO))) begin
                        xoff_in      = 1'b0;
                        xkind_in     = KIND_XON;
                        sts.extra_go = 1'b1;
                     end
                  end
               end
            end
            FUNC_WRITE: begin
               if (enabled_ff) begin
                  tx_wr_en   = 1'b1;
                  rsp_acc_in = 1'b1;
                  tx_flush   = (tx_new == TX_FILL_W'(TX_DEPTH)) || (data_ff == NEWLINE);
                  if (tx_flush) begin
                     tx_fill_in = '0;
                     sts.tx_go  = ok_ff;
                  end else begin
                     tx_fill_in = tx_new;
                  end
                  send_cnt_in = tx_new;
                  acc_in      = 1'b1;
               end
            end
            FUNC_FLUSH: begin
               if (enabled_ff) begin
                  tx_fill_in  = '0;
                  sts.tx_go   = ok_ff && (tx_fill_ff != '0);
                  send_cnt_in = tx_fill_ff;
                  acc_in      = 1'b0;
               end
            end
            default: begin
            end
         endcase
         rsp_valid_in = !sts.tx_go;
         rsp_last_in  = !sts.extra_go;
         rsp_count_in = RX_COUNT_W'(rx_fill_in);
      end

      if (cmd.extra) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = xkind_ff;
      end

      if (cmd.tx_load) begin
         idx_in = '0;
         chk_in = '0;
      end

      if (cmd.tx_send) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_TX;
         rsp_byte_in  = tx_rd_ff;
         rsp_acc_in   = acc_ff;
         rsp_fend_in  = (chk_ff == CHK_W'(CHUNK - 1)) || tx_last;
         rsp_last_in  = tx_last;
         sts.tx_last  = tx_last;
         idx_in       = idx_ff + TX_FILL_W'(1);
         chk_in       = (chk_ff == CHK_W'(CHUNK - 1)) ? '0 : chk_ff + CHK_W'(1);
      end

      // starting the console empties both buffers and lifts XOFF
      if (cfg_wr && cfg_sel) begin
         enabled_in = cfg_wdata[0];
         if (cfg_wdata[0]) begin
            rx_head_in = '0;
            rx_fill_in = '0;
            xoff_in    = 1'b0;
            tx_fill_in = '0;
         end
      end
   end

   // fetch the byte that the next send cycle shows
   assign tx_rd_addr = (idx_in >= TX_FILL_W'(TX_DEPTH)) ? '0 : idx_in[TX_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (rx_wr_en) begin
         rx_mem[rx_wr_addr] <= data_ff;
      end
      rx_rd_ff <= rx_mem[rx_head_ff];
   end

   always_ff @(posedge clock) begin
      if (tx_wr_en) begin
         tx_mem[tx_fill_ff[TX_IDX_W-1:0]] <= data_ff;
      end
      tx_rd_ff <= tx_mem[tx_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= func_type'(req_func);
         data_ff  <= req_data;
         plast_ff <= req_push_last;
         ok_ff    <= req_send_ok;
      end
      send_cnt_ff   <= send_cnt_in;
      idx_ff        <= idx_in;
      chk_ff        <= chk_in;
      acc_ff        <= acc_in;
      xkind_ff      <= xkind_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_fend_ff   <= rsp_fend_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff   <= '0;
         rx_fill_ff   <= '0;
         xoff_ff      <= 1'b0;
         tx_fill_ff   <= '0;
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_head_ff   <= rx_head_in;
         rx_fill_ff   <= rx_fill_in;
         xoff_ff      <= xoff_in;
         tx_fill_ff   <= tx_fill_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cfg_rdata      = cfg_sel ? {{(CSR_DATA_W-1){1'b0}}, enabled_ff} : '0;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_byte_out   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bvalid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_rx_count   = rsp_count_ff;
   assign rsp_frame_end  = rsp_fend_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

>>> rtl/xxcb_top_note.sv
// Bus decode for the single control register of the console buffer.
module xxcb_csr
   import xxcb_pkg::*;
(
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   output logic                  pready,
   output logic                  cfg_wr,
   output logic                  cfg_sel
);

   // register 0 occupies the lower half of the addresses; the upper half reads as zero
   assign pready  = 1'b1;
   assign cfg_sel = !paddr[CSR_ADDR_W-1];
   assign cfg_wr  = psel && penable && pwrite;

endmodule

>>> rtl/xon_xoff_console_buffer.sv
// A result is registered as its transaction leaves the execute state, or each send state
// for transmit bytes, and stays for one cycle. A transaction passes the idle and execute
// states, then the extra state when an XON or XOFF follows, or the load state and one send
// state per byte of a flush, the controller stepping one transmit byte per cycle through the
// registered line-buffer read. The next transaction is taken while the last result is shown;
// the receiver cannot stall. Synchronous reset disables the console and empties both buffers.
module xon_xoff_console_buffer
   import xxcb_pkg::*;
#(
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int CHUNK    = CHUNK_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [DATA_W-1:0]     req_data,
   input  logic                  req_push_last,
   input  logic                  req_send_ok,
   output logic                  rsp_valid,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [DATA_W-1:0]     rsp_byte_out,
   output logic                  rsp_byte_valid,
   output logic                  rsp_accepted,
   output logic [RX_COUNT_W-1:0] rsp_rx_count,
   output logic                  rsp_frame_end,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;
   logic         cfg_wr;
   logic         cfg_sel;

   xxcb_csr u_csr (
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pready  (pready),
      .cfg_wr  (cfg_wr),
      .cfg_sel (cfg_sel)
   );

   xxcb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   xxcb_datapath #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH),
      .CHUNK    (CHUNK)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_data       (req_data),
      .req_push_last  (req_push_last),
      .req_send_ok    (req_send_ok),
      .cfg_wr         (cfg_wr),
      .cfg_sel        (cfg_sel),
      .cfg_wdata      (pwdata),
      .cfg_rdata      (prdata),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_accepted   (rsp_accepted),
      .rsp_rx_count   (rsp_rx_count),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_last       (rsp_last)
   );

endmodule

>>> test/tb.sv
// Self-checking testbench for the XON/XOFF console buffer: predictor, scoreboard and stimulus.
module tb
   import xxcb_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FUNC_W-1:0]     FUNC_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0]     FUNC_SPARE_B = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] ENABLE_ADDR  = 3'd0;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] data;
      logic              push_last;
      logic              send_ok;
   } console_cmd_type;

   typedef struct packed {
      kind_type              kind;
      logic [DATA_W-1:0]     byte_out;
      logic                  byte_valid;
      logic                  accepted;
      logic [RX_COUNT_W-1:0] rx_count;
      logic                  frame_end;
      logic                  last;
   } console_result_type;

   class console_tracker;
      console_result_type pending[$];
      console_result_type step_q[$];
      logic [DATA_W-1:0] rx_mem [RX_DEPTH_DEF];
      logic [5:0]        rx_head = '0;
      logic [6:0]        rx_fill = '0;
      bit                xoff_on = 1'b0;
      logic [DATA_W-1:0] tx_mem [TX_DEPTH_DEF];
      logic [5:0]        tx_fill = '0;
      bit                enabled = 1'b0;
      int errors = 0;
      int results = 0;
      int xoff_sent = 0;
      int xon_sent = 0;
      int tx_sent = 0;
      int drops = 0;

      function void configure(bit v);
         enabled = v;
         if (v) begin
            rx_head = '0;
            rx_fill = '0;
            xoff_on = 1'b0;
            tx_fill = '0;
         end
      endfunction

      function void add(kind_type k, logic [DATA_W-1:0] b, bit v, bit acc, bit fend);
         console_result_type r;
         r.kind       = k;
         r.byte_out   = b;
         r.byte_valid = v;
         r.accepted   = acc;
         r.rx_count   = '0;
         r.frame_end  = fend;
         r.last       = 1'b0;
         step_q.insert(step_q.size(), r);
      endfunction

      // Send the line buffer as CHUNK-sized frames when the link is ready, then empty it.
      function void flush_line(bit ok, bit acc);
         if (!enabled) return;
         if (ok) begin
            for (int i = 0; i < int'(tx_fill); i++) begin
               add(KIND_TX, tx_mem[i], 1'b0, acc,
                   ((i + 1) % CHUNK_DEF == 0) || (i + 1 == int'(tx_fill)));
               tx_sent++;
            end
         end
         tx_fill = '0;
      endfunction

      function void apply_command(console_cmd_type c);
         step_q.delete();
         case (c.func)
            FUNC_PUSH: begin
               if (int'(rx_fill) < RX_DEPTH_DEF) begin
                  rx_mem[6'(rx_head + rx_fill)] = c.data;
                  rx_fill++;
               end else begin
                  drops++;
               end
               add(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b0);
               if (c.push_last && !xoff_on && int'(rx_fill) > RX_DEPTH_DEF * 3 / 4 && c.send_ok)
               begin
                  xoff_on = 1'b1;
                  xoff_sent++;
                  add(KIND_XOFF, 8'h00, 1'b0, 1'b0, 1'b0);
               end
            end
            FUNC_READ, FUNC_PEEK: begin
               if (rx_fill == '0) begin
                  add(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b0);
               end else begin
                  add(KIND_BYTE, rx_mem[rx_head], 1'b1, 1'b0, 1'b0);
                  if (c.func == FUNC_READ) begin
                     rx_head++;
                     rx_fill--;
                     if (xoff_on && int'(rx_fill) < RX_DEPTH_DEF / 4 && c.send_ok) begin
                        xoff_on = 1'b0;
                        xon_sent++;
                        add(KIND_XON, 8'h00, 1'b0, 1'b0, 1'b0);
                     end
                  end
               end
            end
            FUNC_WRITE: begin
               if (!enabled) begin
                  add(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b0);
               end else begin
                  if (int'(tx_fill) >= TX_DEPTH_DEF) flush_line(c.send_ok, 1'b1);
                  tx_mem[tx_fill[4:0]] = c.data;
                  tx_fill++;
                  if (int'(tx_fill) >= TX_DEPTH_DEF || c.data == NEWLINE)
                     flush_line(c.send_ok, 1'b1);
                  if (step_q.size() == 0) add(KIND_STATUS, 8'h00, 1'b0, 1'b1, 1'b0);
               end
            end
            FUNC_FLUSH: begin
               flush_line(c.send_ok, 1'b0);
               if (step_q.size() == 0) add(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b0);
            end
            default: add(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b0);
         endcase
         foreach (step_q[i]) begin
            step_q[i].rx_count = rx_fill;
            step_q[i].last     = (i == step_q.size() - 1);
            pending.insert(pending.size(), step_q[i]);
         end
      endfunction

      function string show(console_result_type r);
         return $sformatf("kind %0d byte %02h valid %0b acc %0b count %0d fend %0b last %0b",
                          r.kind, r.byte_out, r.byte_valid, r.accepted, r.rx_count,
                          r.frame_end, r.last);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 200) $display("MISMATCH: %s", msg);
      endtask

      task match_result(console_result_type got);
         console_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("result with nothing pending: %s", show(got)));
            return;
         end
         want = pending.pop_front();
         results++;
         if (got !== want)
            report($sformatf("result %0d: got %s / want %s", results, show(got), show(want)));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   console_cmd_type       drv;
   logic                  rsp_valid;
   logic [KIND_W-1:0]     rsp_kind;
   logic [DATA_W-1:0]     rsp_byte_out;
   logic                  rsp_byte_valid;
   logic                  rsp_accepted;
   logic [RX_COUNT_W-1:0] rsp_rx_count;
   logic                  rsp_frame_end;
   logic                  rsp_last;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   console_tracker tracker;
   int issued = 0;
   int settings = 0;
   bit quiet = 1'b0;
   bit filling = 1'b1;

   xon_xoff_console_buffer dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (drv.func),
      .req_data       (drv.data),
      .req_push_last  (drv.push_last),
      .req_send_ok    (drv.send_ok),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_accepted   (rsp_accepted),
      .rsp_rx_count   (rsp_rx_count),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Check results before noting a new transaction: a result never belongs to one taken
   // at the same edge.
   always @(posedge clock) begin
      console_result_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got.kind       = kind_type'(rsp_kind);
            got.byte_out   = rsp_byte_out;
            got.byte_valid = rsp_byte_valid;
            got.accepted   = rsp_accepted;
            got.rx_count   = rsp_rx_count;
            got.frame_end  = rsp_frame_end;
            got.last       = rsp_last;
            tracker.match_result(got);
         end
         if (start && !busy) tracker.apply_command(drv);
      end
   end

   function bit link_ready();
      return $urandom_range(0, 4) != 0;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction is taken.
   task automatic issue(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] d, bit pl, bit ok);
      int gap;
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      drv   <= '{f, d, pl, ok};
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      issued++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (tracker.pending.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_enable(bit v);
      logic [CSR_DATA_W-1:0] rd;
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ENABLE_ADDR;
      pwdata  <= CSR_DATA_W'(v);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tracker.configure(v);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd !== CSR_DATA_W'(v))
         tracker.report($sformatf("enable register reads %h after writing %0b", rd, v));
      settings++;
   endtask

   task automatic push_block();
      int len;
      len = $urandom_range(3, 20);
      for (int i = 0; i < len; i++)
         issue(FUNC_PUSH, 8'($urandom), i == len - 1, link_ready());
   endtask

   task automatic read_burst();
      int len;
      len = $urandom_range(2, 16);
      for (int i = 0; i < len; i++)
         issue(($urandom_range(0, 4) == 0) ? FUNC_PEEK : FUNC_READ, 8'($urandom),
               1'($urandom), link_ready());
   endtask

   // Mostly short lines ending in a newline; now and then one long enough to fill the buffer.
   task automatic write_line();
      int len;
      bit ok;
      logic [DATA_W-1:0] d;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
      ok = link_ready();
      for (int i = 0; i < len; i++) begin
         d = 8'($urandom);
         if (i == len - 1 && $urandom_range(0, 2) != 0) d = NEWLINE;
         else if (d == NEWLINE) d = 8'h20;
         issue(FUNC_WRITE, d, 1'($urandom), ok);
      end
   endtask

   task automatic random_phase(int budget);
      int stop;
      int sel;
      stop = issued + budget;
      while (issued < stop) begin
         sel = $urandom_range(0, 9);
         if (sel < 5) begin
            if (filling) push_block();
            else read_burst();
         end else if (sel < 8) begin
            write_line();
         end else if (sel == 8) begin
            issue(FUNC_FLUSH, 8'($urandom), 1'($urandom), link_ready());
         end else begin
            issue(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
         end
         // Swing the receive fill between full and nearly empty to reach XOFF and XON.
         if (int'(tracker.rx_fill) == RX_DEPTH_DEF) filling = 1'b0;
         else if (int'(tracker.rx_fill) < 6) filling = 1'b1;
      end
   endtask

   initial begin
      reset   = 1'b1;
      start   = 1'b0;
      drv     = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      tracker = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Console not started: writes and flushes do nothing, other commands still answer.
      issue(FUNC_WRITE, 8'h41, 1'b0, 1'b1);
      issue(FUNC_FLUSH, 8'h00, 1'b0, 1'b1);
      issue(FUNC_READ, 8'h00, 1'b0, 1'b1);
      issue(FUNC_PEEK, 8'hFF, 1'b1, 1'b0);
      issue(FUNC_QUERY, 8'h00, 1'b0, 1'b1);
      issue(FUNC_SPARE_A, 8'hFF, 1'b1, 1'b1);
      issue(FUNC_SPARE_B, 8'h00, 1'b0, 1'b0);
      issue(FUNC_PUSH, 8'h5A, 1'b1, 1'b1);
      set_enable(1'b1);

      issue(FUNC_PUSH, 8'h00, 1'b0, 1'b1);
      issue(FUNC_PUSH, 8'hFF, 1'b1, 1'b0);
      issue(FUNC_PEEK, 8'h00, 1'b0, 1'b1);
      issue(FUNC_READ, 8'h00, 1'b0, 1'b1);
      issue(FUNC_READ, 8'h00, 1'b0, 1'b0);
      issue(FUNC_READ, 8'h00, 1'b0, 1'b1);
      issue(FUNC_QUERY, 8'hFF, 1'b1, 1'b1);
      issue(FUNC_WRITE, 8'h41, 1'b0, 1'b1);
      issue(FUNC_WRITE, 8'hFF, 1'b1, 1'b1);
      issue(FUNC_WRITE, NEWLINE, 1'b0, 1'b1);
      // Refused newline flush drops the line.
      issue(FUNC_WRITE, 8'h00, 1'b0, 1'b0);
      issue(FUNC_WRITE, NEWLINE, 1'b0, 1'b0);
      issue(FUNC_WRITE, 8'h42, 1'b0, 1'b1);
      issue(FUNC_FLUSH, 8'h00, 1'b0, 1'b1);
      issue(FUNC_FLUSH, 8'h00, 1'b0, 1'b1);
      issue(FUNC_WRITE, 8'h43, 1'b0, 1'b1);
      issue(FUNC_FLUSH, 8'h00, 1'b0, 1'b0);
      issue(FUNC_FLUSH, 8'h00, 1'b0, 1'b1);

      random_phase(55);
      set_enable(1'b0);
      random_phase(20);
      set_enable(1'b1);
      filling = 1'b1;
      random_phase(35);

      drain();
      repeat (20) @(posedge clock);
      $display("Ran %0d transactions over %0d enable writes; %0d results checked.",
               issued, settings, tracker.results);
      $display("Seen: %0d XOFF, %0d XON, %0d transmit bytes, %0d pushes dropped on full.",
               tracker.xoff_sent, tracker.xon_sent, tracker.tx_sent, tracker.drops);
      if (tracker.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout waiting for the console buffer");
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> filelist.f
rtl/xxcb_pkg.sv
rtl/xxcb_ctrl.sv
rtl/xxcb_datapath.sv
rtl/xxcb_top_note.sv
rtl/xon_xoff_console_buffer.sv
test/tb.sv
